// ===== hw/rtl/pca_pkg.sv =====
// Shared constants, payload structs and codes for the Pearson correlation accumulator.
// Used by pca_serial_alu, pearson_correlation_accumulator and tb_top; depends on nothing else.
package pca_pkg;

    localparam int MAX_PAIRS   = 4096;
    localparam int SAMPLE_BITS = 16;

    localparam int FIELD_W = 16;
    localparam int CORR_W  = 16;
    localparam int PAIRS_W = 13;
    localparam int Q_BITS  = 15;

    localparam int XW    = (SAMPLE_BITS > FIELD_W) ? SAMPLE_BITS : FIELD_W;
    localparam int CNT_W = $clog2(MAX_PAIRS + 1);
    localparam int SUM_W = SAMPLE_BITS + CNT_W;
    localparam int MAG_W = SUM_W - 1;
    localparam int SQ_W  = 2 * SAMPLE_BITS - 2 + CNT_W;
    localparam int SXY_W = SQ_W + 1;
    localparam int VW    = 2 * MAG_W;
    localparam int KW    = Q_BITS + 1;
    localparam int BIT_W = $clog2(KW);
    localparam int MPW   = (VW > 2 * KW) ? VW : 2 * KW;
    localparam int BW    = 2 * VW + 2 * KW;

    localparam int CAND_LIMIT = 2 ** Q_BITS;
    localparam int CORR_MAX   = 2 ** (CORR_W - 1) - 1;

    typedef struct packed {
        logic signed [FIELD_W-1:0] x_sample;
        logic signed [FIELD_W-1:0] y_sample;
        logic                      last_pair;
    } sample_t;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_DEGENERATE = 2'd1,
        STATUS_OVERFLOW   = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [CORR_W-1:0] correlation;
        logic [PAIRS_W-1:0]       pairs_used;
        status_t                  status;
    } result_t;

    typedef enum logic [1:0] {
        ALU_MUL = 2'd0,
        ALU_ADD = 2'd1,
        ALU_SUB = 2'd2
    } alu_op_t;

    typedef struct packed {
        logic          start;
        alu_op_t       op;
        logic [BW-1:0] a;
        logic [BW-1:0] b;
    } alu_cmd_t;

    typedef struct packed {
        logic          busy;
        logic          ge;
        logic [BW-1:0] result;
    } alu_rsp_t;

endpackage

// ===== hw/rtl/pca_serial_alu.sv =====
// Serial shift-and-add multiplier that also performs single-step add and subtract.
// Depends on pca_pkg for the widths and the command and response structs.
module pca_serial_alu
    import pca_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  alu_cmd_t cmd,
    output alu_rsp_t rsp
);

    logic [BW-1:0]  acc_reg, acc_next;
    logic [BW-1:0]  mcand_reg, mcand_next;
    logic [MPW-1:0] mplier_reg, mplier_next;
    logic           sub_reg, sub_next;
    logic           ge_reg, ge_next;
    logic [BW-1:0]  addend;
    logic [BW-1:0]  sum;
    logic           carry;

    assign addend         = sub_reg ? ~mcand_reg : mcand_reg;
    assign {carry, sum}   = {1'b0, acc_reg} + {1'b0, addend} + {{BW{1'b0}}, sub_reg};

    always_comb
    begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        sub_next    = sub_reg;
        ge_next     = ge_reg;
        if (cmd.start)
        begin
            case (cmd.op)
                ALU_MUL:
                begin
                    acc_next    = '0;
                    mcand_next  = cmd.a;
                    mplier_next = cmd.b[MPW-1:0];
                    sub_next    = 1'b0;
                end
                ALU_ADD:
                begin
                    acc_next    = cmd.a;
                    mcand_next  = cmd.b;
                    mplier_next = MPW'(1);
                    sub_next    = 1'b0;
                end
                ALU_SUB:
                begin
                    acc_next    = cmd.a;
                    mcand_next  = cmd.b;
                    mplier_next = MPW'(1);
                    sub_next    = 1'b1;
                end
                default:
                begin
                    mplier_next = '0;
                end
            endcase
        end
        else if (mplier_reg != '0)
        begin
            if (mplier_reg[0])
            begin
                acc_next = sum;
                ge_next  = carry;
            end
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mplier_reg <= '0;
            sub_reg    <= 1'b0;
            ge_reg     <= 1'b0;
        end
        else
        begin
            mplier_reg <= mplier_next;
            sub_reg    <= sub_next;
            ge_reg     <= ge_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
    end

    assign rsp.busy   = (mplier_reg != '0);
    assign rsp.ge     = ge_reg;
    assign rsp.result = acc_reg;

endmodule

// ===== hw/rtl/pearson_correlation_accumulator.sv =====
// Top level: accumulates sample pairs and sequences the final correlation on the last pair.
// Depends on pca_pkg and on pca_serial_alu.
//
//   Channel   Handshake                        Payload
//   sample    sample_valid / sample_stall      sample_t: x_sample, y_sample, last_pair
//   result    result_valid / result_stall      result_t: correlation, pairs_used, status
//
// A pair is taken in ST_IDLE, then passes ST_ACC_XX, ST_ACC_YY and ST_ACC_XY through the single sample multiplier.
// On the last pair the serial unit, one multiplier bit per cycle, works out the variances
// and, unless the set is degenerate, the covariance and a sixteen-step search for r.
// Reset clears the count, the sums, the overflow flag and result_valid at once; there is no clearing pass.
// A result waits in its output register while new pairs are taken; only the next result
// waits for result_stall to drop.
module pearson_correlation_accumulator
    import pca_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    sample_valid,
    output logic    sample_stall,
    input  sample_t sample,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_ACC_XX = 7'b0000010,
        ST_ACC_YY = 7'b0000100,
        ST_ACC_XY = 7'b0001000,
        ST_ISSUE  = 7'b0010000,
        ST_WAIT   = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

    typedef enum logic [3:0] {
        SP_NSXX = 4'd0,
        SP_SX2  = 4'd1,
        SP_VA   = 4'd2,
        SP_NSYY = 4'd3,
        SP_SY2  = 4'd4,
        SP_VB   = 4'd5,
        SP_NSXY = 4'd6,
        SP_SXSY = 4'd7,
        SP_COV  = 4'd8,
        SP_NEG  = 4'd9,
        SP_COV2 = 4'd10,
        SP_VAB  = 4'd11,
        SP_K2   = 4'd12,
        SP_LHS  = 4'd13,
        SP_CMP  = 4'd14
    } step_t;

    state_t state_reg, state_next;
    step_t  step_reg, step_next;
    logic [BIT_W-1:0] bit_reg, bit_next;

    logic [CNT_W-1:0]        count_reg, count_next;
    logic signed [SUM_W-1:0] sum_x_reg, sum_x_next;
    logic signed [SUM_W-1:0] sum_y_reg, sum_y_next;
    logic [SQ_W-1:0]         sum_xx_reg, sum_xx_next;
    logic [SQ_W-1:0]         sum_yy_reg, sum_yy_next;
    logic signed [SXY_W-1:0] sum_xy_reg, sum_xy_next;
    logic                    ovf_reg, ovf_next;
    logic                    result_valid_reg, result_valid_next;

    logic signed [SAMPLE_BITS-1:0] x_reg, x_next, y_reg, y_next;
    logic                          last_reg, last_next;
    logic [VW-1:0]                 r0_reg, r0_next;
    logic [VW-1:0]                 va_reg, va_next;
    logic [VW-1:0]                 vb_reg, vb_next;
    logic [VW-1:0]                 c_reg, c_next;
    logic                          csign_reg, csign_next;
    logic                          neg_reg, neg_next;
    logic                          degen_reg, degen_next;
    logic [BW-1:0]                 t_reg, t_next;
    logic [2*VW-1:0]               ab_reg, ab_next;
    logic [2*KW-1:0]               k2_reg, k2_next;
    logic [KW-1:0]                 m_reg, m_next;
    result_t                       result_reg, result_next;

    logic [XW-1:0]                   x_field, y_field;
    logic signed [SAMPLE_BITS-1:0]   x_in, y_in, mul_a, mul_b;
    logic signed [2*SAMPLE_BITS-1:0] prod;
    logic [SUM_W-1:0]                neg_x, neg_y;
    logic [SXY_W-1:0]                neg_xy;
    logic [MAG_W-1:0]                mag_x, mag_y;
    logic [SQ_W-1:0]                 mag_xy;
    logic                            psign, qsign;
    logic [KW-1:0]                   cand;
    logic [KW:0]                     k_wide;
    logic [KW-1:0]                   k_val;
    logic                            cand_ok;
    logic [VW-1:0]                   vb_new;
    logic [CORR_W-1:0]               corr_val;
    logic                            load;

    alu_cmd_t alu_cmd;
    alu_rsp_t alu_rsp;

    pca_serial_alu u_alu
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (alu_cmd),
        .rsp   (alu_rsp)
    );

    assign x_field = XW'($unsigned(sample.x_sample));
    assign y_field = XW'($unsigned(sample.y_sample));
    assign x_in    = x_field[SAMPLE_BITS-1:0];
    assign y_in    = y_field[SAMPLE_BITS-1:0];

    assign mul_a = (state_reg == ST_ACC_YY) ? y_reg : x_reg;
    assign mul_b = (state_reg == ST_ACC_XX) ? x_reg : y_reg;
    assign prod  = mul_a * mul_b;

    assign neg_x  = -sum_x_reg;
    assign neg_y  = -sum_y_reg;
    assign neg_xy = -sum_xy_reg;
    assign mag_x  = sum_x_reg[SUM_W-1] ? neg_x[MAG_W-1:0] : sum_x_reg[MAG_W-1:0];
    assign mag_y  = sum_y_reg[SUM_W-1] ? neg_y[MAG_W-1:0] : sum_y_reg[MAG_W-1:0];
    assign mag_xy = sum_xy_reg[SXY_W-1] ? neg_xy[SQ_W-1:0] : sum_xy_reg[SQ_W-1:0];
    assign psign  = sum_xy_reg[SXY_W-1];
    assign qsign  = sum_x_reg[SUM_W-1] ^ sum_y_reg[SUM_W-1];

    assign cand    = m_reg | (KW'(1) << bit_reg);
    assign cand_ok = (cand <= KW'(CAND_LIMIT));
    assign k_wide  = {cand, 1'b0} - (KW + 1)'(1);
    assign k_val   = k_wide[KW-1:0];

    assign vb_new = alu_rsp.ge ? alu_rsp.result[VW-1:0] : '0;

    always_comb
    begin
        alu_cmd.start = (state_reg == ST_ISSUE) && !((step_reg == SP_K2) && !cand_ok);
        alu_cmd.op    = ALU_MUL;
        alu_cmd.a     = '0;
        alu_cmd.b     = '0;
        case (step_reg)
            SP_NSXX:
            begin
                alu_cmd.a = BW'(sum_xx_reg);
                alu_cmd.b = BW'(count_reg);
            end
            SP_SX2:
            begin
                alu_cmd.a = BW'(mag_x);
                alu_cmd.b = BW'(mag_x);
            end
            SP_VA, SP_VB:
            begin
                alu_cmd.op = ALU_SUB;
                alu_cmd.a  = BW'(r0_reg);
                alu_cmd.b  = alu_rsp.result;
            end
            SP_NSYY:
            begin
                alu_cmd.a = BW'(sum_yy_reg);
                alu_cmd.b = BW'(count_reg);
            end
            SP_SY2:
            begin
                alu_cmd.a = BW'(mag_y);
                alu_cmd.b = BW'(mag_y);
            end
            SP_NSXY:
            begin
                alu_cmd.a = BW'(mag_xy);
                alu_cmd.b = BW'(count_reg);
            end
            SP_SXSY:
            begin
                alu_cmd.a = BW'(mag_x);
                alu_cmd.b = BW'(mag_y);
            end
            SP_COV:
            begin
                alu_cmd.op = (psign != qsign) ? ALU_ADD : ALU_SUB;
                alu_cmd.a  = BW'(r0_reg);
                alu_cmd.b  = alu_rsp.result;
            end
            SP_NEG:
            begin
                alu_cmd.op = ALU_SUB;
                alu_cmd.b  = alu_rsp.result;
            end
            SP_COV2:
            begin
                alu_cmd.a = BW'(c_reg);
                alu_cmd.b = BW'(c_reg);
            end
            SP_VAB:
            begin
                alu_cmd.a = BW'(va_reg);
                alu_cmd.b = BW'(vb_reg);
            end
            SP_K2:
            begin
                alu_cmd.a = BW'(k_val);
                alu_cmd.b = BW'(k_val);
            end
            SP_LHS:
            begin
                alu_cmd.a = BW'(ab_reg);
                alu_cmd.b = BW'(k2_reg);
            end
            SP_CMP:
            begin
                alu_cmd.op = ALU_SUB;
                alu_cmd.a  = t_reg;
                alu_cmd.b  = alu_rsp.result;
            end
            default:
            begin
                alu_cmd.a = '0;
            end
        endcase
    end

    always_comb
    begin
        if (degen_reg)
        begin
            corr_val = '0;
        end
        else if (csign_reg)
        begin
            corr_val = CORR_W'(-m_reg);
        end
        else if (m_reg == KW'(CAND_LIMIT))
        begin
            corr_val = CORR_W'(CORR_MAX);
        end
        else
        begin
            corr_val = CORR_W'(m_reg);
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        bit_next    = bit_reg;
        count_next  = count_reg;
        sum_x_next  = sum_x_reg;
        sum_y_next  = sum_y_reg;
        sum_xx_next = sum_xx_reg;
        sum_yy_next = sum_yy_reg;
        sum_xy_next = sum_xy_reg;
        ovf_next    = ovf_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        last_next   = last_reg;
        r0_next     = r0_reg;
        va_next     = va_reg;
        vb_next     = vb_reg;
        c_next      = c_reg;
        csign_next  = csign_reg;
        neg_next    = neg_reg;
        degen_next  = degen_reg;
        t_next      = t_reg;
        ab_next     = ab_reg;
        k2_next     = k2_reg;
        m_next      = m_reg;
        result_next = result_reg;
        load        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    if (count_reg == CNT_W'(MAX_PAIRS))
                    begin
                        ovf_next = 1'b1;
                        if (sample.last_pair)
                        begin
                            step_next  = SP_NSXX;
                            state_next = ST_ISSUE;
                        end
                    end
                    else
                    begin
                        x_next     = x_in;
                        y_next     = y_in;
                        last_next  = sample.last_pair;
                        state_next = ST_ACC_XX;
                    end
                end
            end
            ST_ACC_XX:
            begin
                sum_x_next  = sum_x_reg + SUM_W'(x_reg);
                sum_y_next  = sum_y_reg + SUM_W'(y_reg);
                sum_xx_next = sum_xx_reg + SQ_W'(prod[2*SAMPLE_BITS-2:0]);
                count_next  = count_reg + CNT_W'(1);
                state_next  = ST_ACC_YY;
            end
            ST_ACC_YY:
            begin
                sum_yy_next = sum_yy_reg + SQ_W'(prod[2*SAMPLE_BITS-2:0]);
                state_next  = ST_ACC_XY;
            end
            ST_ACC_XY:
            begin
                sum_xy_next = sum_xy_reg + SXY_W'(prod);
                if (last_reg)
                begin
                    step_next  = SP_NSXX;
                    state_next = ST_ISSUE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ISSUE:
            begin
                if (alu_cmd.start)
                begin
                    state_next = ST_WAIT;
                end
                else if (bit_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    bit_next = bit_reg - BIT_W'(1);
                end
            end
            ST_WAIT:
            begin
                if (!alu_rsp.busy)
                begin
                    state_next = ST_ISSUE;
                    case (step_reg)
                        SP_NSXX:
                        begin
                            r0_next   = alu_rsp.result[VW-1:0];
                            step_next = SP_SX2;
                        end
                        SP_SX2:
                        begin
                            step_next = SP_VA;
                        end
                        SP_VA:
                        begin
                            va_next   = alu_rsp.ge ? alu_rsp.result[VW-1:0] : '0;
                            step_next = SP_NSYY;
                        end
                        SP_NSYY:
                        begin
                            r0_next   = alu_rsp.result[VW-1:0];
                            step_next = SP_SY2;
                        end
                        SP_SY2:
                        begin
                            step_next = SP_VB;
                        end
                        SP_VB:
                        begin
                            vb_next    = vb_new;
                            degen_next = (count_reg < CNT_W'(2)) || (va_reg == '0)
                                         || (vb_new == '0);
                            if ((count_reg < CNT_W'(2)) || (va_reg == '0) || (vb_new == '0))
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                step_next = SP_NSXY;
                            end
                        end
                        SP_NSXY:
                        begin
                            r0_next   = alu_rsp.result[VW-1:0];
                            step_next = SP_SXSY;
                        end
                        SP_SXSY:
                        begin
                            step_next = SP_COV;
                        end
                        SP_COV:
                        begin
                            r0_next   = alu_rsp.result[VW-1:0];
                            neg_next  = (psign == qsign) && !alu_rsp.ge;
                            step_next = SP_NEG;
                        end
                        SP_NEG:
                        begin
                            c_next     = neg_reg ? alu_rsp.result[VW-1:0] : r0_reg;
                            csign_next = psign ^ neg_reg;
                            step_next  = SP_COV2;
                        end
                        SP_COV2:
                        begin
                            t_next    = alu_rsp.result << (2 * KW);
                            step_next = SP_VAB;
                        end
                        SP_VAB:
                        begin
                            ab_next   = alu_rsp.result[2*VW-1:0];
                            m_next    = '0;
                            bit_next  = BIT_W'(KW - 1);
                            step_next = SP_K2;
                        end
                        SP_K2:
                        begin
                            k2_next   = alu_rsp.result[2*KW-1:0];
                            step_next = SP_LHS;
                        end
                        SP_LHS:
                        begin
                            step_next = SP_CMP;
                        end
                        SP_CMP:
                        begin
                            if (alu_rsp.ge)
                            begin
                                m_next = cand;
                            end
                            if (bit_reg == '0)
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                bit_next  = bit_reg - BIT_W'(1);
                                step_next = SP_K2;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_DONE:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    load                    = 1'b1;
                    result_next.correlation = corr_val;
                    result_next.pairs_used  = PAIRS_W'(count_reg);
                    result_next.status      = ovf_reg ? STATUS_OVERFLOW
                                              : (degen_reg ? STATUS_DEGENERATE : STATUS_OK);
                    count_next  = '0;
                    sum_x_next  = '0;
                    sum_y_next  = '0;
                    sum_xx_next = '0;
                    sum_yy_next = '0;
                    sum_xy_next = '0;
                    ovf_next    = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= SP_NSXX;
            bit_reg          <= '0;
            count_reg        <= '0;
            sum_x_reg        <= '0;
            sum_y_reg        <= '0;
            sum_xx_reg       <= '0;
            sum_yy_reg       <= '0;
            sum_xy_reg       <= '0;
            ovf_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            bit_reg          <= bit_next;
            count_reg        <= count_next;
            sum_x_reg        <= sum_x_next;
            sum_y_reg        <= sum_y_next;
            sum_xx_reg       <= sum_xx_next;
            sum_yy_reg       <= sum_yy_next;
            sum_xy_reg       <= sum_xy_next;
            ovf_reg          <= ovf_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        y_reg      <= y_next;
        last_reg   <= last_next;
        r0_reg     <= r0_next;
        va_reg     <= va_next;
        vb_reg     <= vb_next;
        c_reg      <= c_next;
        csign_reg  <= csign_next;
        neg_reg    <= neg_next;
        degen_reg  <= degen_next;
        t_reg      <= t_next;
        ab_reg     <= ab_next;
        k2_reg     <= k2_next;
        m_reg      <= m_next;
        result_reg <= result_next;
    end

    assign sample_stall = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for pearson_correlation_accumulator: directed, back-pressure
// and random data sets, each result checked against an exact integer predictor.
// Depends on pca_pkg and on the block's RTL only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import pca_pkg::*;

    localparam int RANDOM_ITEMS = 1000;
    localparam int QUIET_ITEMS  = 300;
    localparam int HOLD_CYCLES  = 4000;
    localparam int DRAIN_CYCLES = 1200;

    typedef enum int {
        SHAPE_RANDOM,
        SHAPE_TRACKING,
        SHAPE_OPPOSED,
        SHAPE_TINY,
        SHAPE_FLAT_X,
        SHAPE_FLAT_Y,
        SHAPE_EXTREME
    } set_shape_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    sample_valid = 1'b0;
    logic    sample_stall;
    sample_t sample = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    int      pair_total = 0;
    longint  sum_x = 0;
    longint  sum_y = 0;
    longint  sum_xx = 0;
    longint  sum_yy = 0;
    longint  sum_xy = 0;
    bit      excess_seen = 1'b0;
    result_t pending_results[$];

    int mismatch_count = 0;
    bit sender_idles = 1'b1;
    bit receiver_idles = 1'b1;
    int receiver_hold = 0;

    pearson_correlation_accumulator DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint sample_value(input logic signed [FIELD_W-1:0] field);
        longint v;
        v = field;
        return (v <<< (64 - SAMPLE_BITS)) >>> (64 - SAMPLE_BITS);
    endfunction

    function automatic int random_sample();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic int extreme_value();
        case ($urandom_range(0, 3))
            0:       return -32768;
            1:       return -1;
            2:       return 0;
            default: return 32767;
        endcase
    endfunction

    // Accumulates one item and, on the last pair of a set, works out the exact Q1.15 result.
    function automatic bit correlation_update(input sample_t item, output result_t want);
        logic signed [127:0] n, sx, sy, sxx, syy, sxy, var_x, var_y, cov;
        logic [255:0] spread, bound, trial;
        longint x, y, k;
        int lo, hi, mid, corr;
        bit flat, negative;
        want = '0;
        if (pair_total < MAX_PAIRS)
        begin
            x = sample_value(item.x_sample);
            y = sample_value(item.y_sample);
            sum_x += x;
            sum_y += y;
            sum_xx += x * x;
            sum_yy += y * y;
            sum_xy += x * y;
            pair_total++;
        end
        else
            excess_seen = 1'b1;
        if (!item.last_pair)
            return 1'b0;

        n = pair_total;
        sx = sum_x;
        sy = sum_y;
        sxx = sum_xx;
        syy = sum_yy;
        sxy = sum_xy;
        var_x = n * sxx - sx * sx;
        var_y = n * syy - sy * sy;
        if (var_x < 0)
            var_x = 0;
        if (var_y < 0)
            var_y = 0;
        flat = (pair_total < 2) || (var_x == 0) || (var_y == 0);
        corr = 0;
        if (!flat)
        begin
            cov = n * sxy - sx * sy;
            negative = cov < 0;
            if (negative)
                cov = -cov;
            bound = cov;
            bound = (bound * bound) << 32;
            spread = var_x;
            trial = var_y;
            spread = spread * trial;
            lo = 0;
            hi = CAND_LIMIT;
            while (lo < hi)
            begin
                mid = (lo + hi + 1) / 2;
                k = 2 * mid - 1;
                trial = k * k;
                trial = spread * trial;
                if (trial <= bound)
                    lo = mid;
                else
                    hi = mid - 1;
            end
            corr = negative ? -lo : lo;
            if (corr > CORR_MAX)
                corr = CORR_MAX;
        end
        want.correlation = corr[CORR_W-1:0];
        want.pairs_used = pair_total[PAIRS_W-1:0];
        if (excess_seen)
            want.status = STATUS_OVERFLOW;
        else if (flat)
            want.status = STATUS_DEGENERATE;
        else
            want.status = STATUS_OK;
        pair_total = 0;
        sum_x = 0;
        sum_y = 0;
        sum_xx = 0;
        sum_yy = 0;
        sum_xy = 0;
        excess_seen = 1'b0;
        return 1'b1;
    endfunction

    task automatic send_pair(input int x,
                             input int y,
                             input logic last);
        sample_t item;
        result_t want;
        item.x_sample = FIELD_W'(x);
        item.y_sample = FIELD_W'(y);
        item.last_pair = last;
        while (sender_idles && $urandom_range(0, 99) < 35)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample <= item;
        do
            @(posedge clk);
        while (sample_stall);
        if (correlation_update(item, want))
            pending_results = {pending_results, want};
    endtask

    task automatic send_random_set(input int len, input set_shape_t shape);
        int i, x, y, flat, scale;
        flat = random_sample();
        for (i = 0; i < len; i++)
        begin
            x = random_sample();
            y = random_sample();
            scale = 1 << $urandom_range(0, 14);
            case (shape)
                SHAPE_TRACKING:
                    y = x + int'($urandom_range(0, 2 * scale)) - scale;
                SHAPE_OPPOSED:
                    y = -x + int'($urandom_range(0, 2 * scale)) - scale;
                SHAPE_TINY:
                begin
                    x = int'($urandom_range(0, 8)) - 4;
                    y = int'($urandom_range(0, 8)) - 4;
                end
                SHAPE_FLAT_X:
                    x = flat;
                SHAPE_FLAT_Y:
                    y = flat;
                SHAPE_EXTREME:
                begin
                    x = extreme_value();
                    y = extreme_value();
                end
                default:
                    ;
            endcase
            if (y > 32767)
                y = 32767;
            else if (y < -32768)
                y = -32768;
            send_pair(x, y, i == len - 1);
        end
    endtask

    task automatic wait_drained();
        sample_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_edge_sets();
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
        // A lone pair is too few for a correlation.
        send_pair(-32768, 32767, 1'b1);
        // Perfect positive and negative correlation at the sample extremes.
        send_pair(-32768, -32768, 1'b0);
        send_pair(32767, 32767, 1'b1);
        send_pair(-32768, 32767, 1'b0);
        send_pair(32767, -32768, 1'b1);
        send_pair(0, 0, 1'b0);
        send_pair(0, 0, 1'b1);
        send_pair(7, -32768, 1'b0);
        send_pair(7, 100, 1'b0);
        send_pair(7, 32767, 1'b1);
        send_pair(12345, 32767, 1'b0);
        send_pair(-12345, 32767, 1'b0);
        send_pair(0, 32767, 1'b1);
        send_pair(1, -1, 1'b0);
        send_pair(-1, -1, 1'b0);
        send_pair(32767, 0, 1'b0);
        send_pair(-2, 5, 1'b0);
        send_pair(100, -200, 1'b1);
        wait_drained();
    endtask

    task automatic test_result_backlog();
        int i;
        receiver_hold = HOLD_CYCLES;
        for (i = 0; i < 5; i++)
            send_random_set(3, SHAPE_RANDOM);
        wait_drained();
    endtask

    task automatic test_random_sets();
        int sent, len;
        set_shape_t shape;
        sent = 0;
        sender_idles = 1'b0;
        receiver_idles = 1'b0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent >= QUIET_ITEMS)
            begin
                sender_idles = 1'b1;
                receiver_idles = 1'b1;
            end
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 16);
            shape = set_shape_t'($urandom_range(SHAPE_RANDOM, SHAPE_EXTREME));
            send_random_set(len, shape);
            sent += len;
        end
        wait_drained();
    endtask

    always @(posedge clk)
    begin
        if (receiver_hold > 0)
        begin
            receiver_hold--;
            result_stall <= 1'b1;
        end
        else
            result_stall <= receiver_idles && ($urandom_range(0, 99) < 35);
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected item, correlation %0d, pairs_used %0d, status %0d",
                         $time, result.correlation, result.pairs_used, result.status);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.correlation !== want.correlation)
                begin
                    $display("%0t: correlation expected %0d, got %0d",
                             $time, want.correlation, result.correlation);
                    mismatch_count++;
                end
                if (result.pairs_used !== want.pairs_used)
                begin
                    $display("%0t: pairs_used expected %0d, got %0d",
                             $time, want.pairs_used, result.pairs_used);
                    mismatch_count++;
                end
                if (result.status !== want.status)
                begin
                    $display("%0t: status expected %0d, got %0d",
                             $time, want.status, result.status);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_edge_sets();
        test_result_backlog();
        test_random_sets();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    initial
    begin
        #30_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/pca_pkg.sv
hw/rtl/pca_serial_alu.sv
hw/rtl/pearson_correlation_accumulator.sv
bench/tb_top.sv
